// ===== src/lef_pkg.sv =====
// Shared types and constants for the 3x3 Laplacian edge filter.
// Used by the window cells, the line buffer and the top level; no dependencies.
package lef_pkg;

  localparam int WidthW    = 11;
  localparam int HeightW   = 13;
  localparam int CountW    = 23;
  localparam int GrayW     = 8;
  localparam int CfgDataW  = 13;
  localparam int CfgIndexW = 1;

  localparam int MaxWidthDefault = 1024;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd512;
  localparam logic [HeightW-1:0] HeightReset = 13'd512;

  localparam logic [CfgIndexW-1:0] RegImageWidth  = 1'd0;
  localparam logic [CfgIndexW-1:0] RegImageHeight = 1'd1;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] filtered_pixel;
    logic       last_of_frame;
  } out_word_t;

  // One column of the 3x3 window: top, middle and bottom gray values.
  typedef struct packed {
    logic [GrayW-1:0] top;
    logic [GrayW-1:0] mid;
    logic [GrayW-1:0] bot;
  } column_t;

  // One line buffer entry: gray from two rows up and from the row above.
  typedef struct packed {
    logic [GrayW-1:0] two_above;
    logic [GrayW-1:0] above;
  } line_entry_t;

endpackage

// ===== src/laplacian_edge_filter_3x3.sv =====
// The pixel completing a result word passes stage one and then the output register.
// One word per cycle if not stalled; the single-port-per-direction line buffer sets that pace.
// The first image_width+1 words of a frame give no result; image_width+1 flush words drain it.
// Reset and any register write clear counters, window and pipeline valid bits at once.
// The line buffer is never swept: rows not yet written in a frame read as zero by row masking.
module laplacian_edge_filter_3x3 #(
  parameter int MAX_WIDTH = lef_pkg::MaxWidthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  lef_pkg::in_word_t                pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output lef_pkg::out_word_t               result,
  input  logic                             cfg_wen,
  input  logic [lef_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [lef_pkg::CfgDataW-1:0]     cfg_wdata
);

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int WhW   = lef_pkg::CountW + 1;
  localparam int GrayW = lef_pkg::GrayW;

  typedef struct packed {
    logic [GrayW-1:0] gray;
    logic [AddrW-1:0] addr;
    logic             col_first;
    logic             col_in;
    logic             produce;
    logic             last;
    logic             above_ok;
    logic             two_above_ok;
  } stage_t;

  logic [lef_pkg::WidthW-1:0]  image_width;
  logic [lef_pkg::HeightW-1:0] image_height;
  logic [lef_pkg::WidthW-1:0]  w_eff;
  logic [lef_pkg::HeightW-1:0] h_eff;
  logic [WhW-1:0]              frame_size;

  logic [lef_pkg::WidthW-1:0]  col;
  logic [lef_pkg::WidthW-1:0]  col_next;
  logic [lef_pkg::HeightW-1:0] row;
  logic [lef_pkg::HeightW-1:0] row_next;
  logic [lef_pkg::CountW-1:0]  count;
  logic [lef_pkg::CountW-1:0]  count_next;

  logic             flush;
  logic             take;
  logic             produce;
  logic             last;
  logic             col_in;
  logic [9:0]       rgb_sum;
  logic [19:0]      div_prod;
  logic [GrayW-1:0] gray;

  logic   s1_valid;
  stage_t s1;
  logic   s1_move;
  logic   out_free;

  lef_pkg::line_entry_t rd_data;
  lef_pkg::line_entry_t wr_data;
  lef_pkg::column_t     new_col;
  lef_pkg::column_t     shift_col;
  lef_pkg::column_t     cell2_din;
  lef_pkg::column_t     cell1_q;
  lef_pkg::column_t     cell2_q;
  logic                 cell1_clr;
  logic                 cell2_clr;

  logic signed [10:0] acc;
  logic [GrayW-1:0]   res;

  // Configuration registers and effective frame size.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lef_pkg::WidthReset;
      image_height <= lef_pkg::HeightReset;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        lef_pkg::RegImageWidth:  image_width  <= cfg_wdata[lef_pkg::WidthW-1:0];
        lef_pkg::RegImageHeight: image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = lef_pkg::WidthW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = lef_pkg::WidthW'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? lef_pkg::HeightW'(1) : image_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size <= WhW'(32'(lef_pkg::WidthReset) * 32'(lef_pkg::HeightReset));
    end else begin
      frame_size <= WhW'(w_eff) * WhW'(h_eff);
    end
  end

  // Input side: gray conversion and raster position.
  assign out_free    = !result_valid || !result_stall;
  assign s1_move     = s1_valid && (!s1.produce || out_free);
  assign pixel_stall = s1_valid && !s1_move;

  assign flush   = row >= h_eff;
  assign take    = pixel_valid && !pixel_stall && (flush || !pixel.mode);
  assign produce = (row >= lef_pkg::HeightW'(2)) ||
                   ((row == lef_pkg::HeightW'(1)) && (col != '0));
  assign last    = produce && ((WhW'(count) + WhW'(1)) >= frame_size);
  assign col_in  = col < w_eff;

  assign rgb_sum  = 10'(pixel.red) + 10'(pixel.green) + 10'(pixel.blue);
  assign div_prod = 20'(rgb_sum) * 20'(683);
  assign gray     = flush ? '0 : div_prod[18:11];

  always_comb begin
    col_next   = col;
    row_next   = row;
    count_next = count;
    if (last) begin
      col_next   = '0;
      row_next   = '0;
      count_next = '0;
    end else begin
      if (!flush) begin
        if ((12'(col) + 12'd1) >= 12'(w_eff)) begin
          col_next = '0;
          row_next = row + lef_pkg::HeightW'(1);
        end else begin
          col_next = col + lef_pkg::WidthW'(1);
        end
      end else if (col_in) begin
        col_next = col + lef_pkg::WidthW'(1);
      end
      if (produce) begin
        count_next = count + lef_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      col   <= '0;
      row   <= '0;
      count <= '0;
    end else if (take) begin
      col   <= col_next;
      row   <= row_next;
      count <= count_next;
    end
  end

  // Stage one: line buffer data arrives, window shifts, Laplacian is formed.
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.gray         <= gray;
      s1.addr         <= AddrW'(col);
      s1.col_first    <= (col == '0);
      s1.col_in       <= col_in;
      s1.produce      <= produce;
      s1.last         <= last;
      s1.above_ok     <= (row >= lef_pkg::HeightW'(1));
      s1.two_above_ok <= (row >= lef_pkg::HeightW'(2));
    end
  end

  lef_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (take && col_in),
    .rd_addr (AddrW'(col)),
    .rd_data (rd_data),
    .wr_en   (s1_move && s1.col_in),
    .wr_addr (s1.addr),
    .wr_data (wr_data)
  );

  always_comb begin
    new_col.top = s1.two_above_ok ? rd_data.two_above : '0;
    new_col.mid = s1.above_ok ? rd_data.above : '0;
    new_col.bot = s1.gray;

    wr_data.two_above = new_col.mid;
    wr_data.above     = s1.gray;

    cell2_din = s1.col_in ? new_col : '0;
    shift_col = s1.col_first ? '0 : cell2_din;

    cell1_clr = rst || cfg_wen || (s1_move && (s1.col_first || s1.last));
    cell2_clr = rst || cfg_wen || (s1_move && s1.last);
  end

  lef_cell u_cell1 (
    .clk (clk),
    .clr (cell1_clr),
    .en  (s1_move),
    .din (cell2_q),
    .q   (cell1_q)
  );

  lef_cell u_cell2 (
    .clk (clk),
    .clr (cell2_clr),
    .en  (s1_move),
    .din (cell2_din),
    .q   (cell2_q)
  );

  always_comb begin
    acc = $signed({1'b0, cell2_q.mid, 2'b00})
        - $signed({3'b000, cell2_q.top})
        - $signed({3'b000, cell2_q.bot})
        - $signed({3'b000, cell1_q.mid})
        - $signed({3'b000, shift_col.mid});
    if (acc[10]) begin
      res = '0;
    end else if (acc > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = acc[7:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst || cfg_wen) begin
      result_valid <= 1'b0;
    end else if (s1_move && s1.produce) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1.produce) begin
      result.filtered_pixel <= res;
      result.last_of_frame  <= s1.last;
    end
  end

endmodule

// ===== src/lef_cell.sv =====
// One window column cell of the Laplacian filter; it loads the column on din on a shift.
// Depends on lef_pkg for the column type.
module lef_cell (
  input  logic             clk,
  input  logic             clr,
  input  logic             en,
  input  lef_pkg::column_t din,
  output lef_pkg::column_t q
);

  always_ff @(posedge clk) begin
    if (clr) begin
      q <= '0;
    end else if (en) begin
      q <= din;
    end
  end

endmodule

// ===== src/lef_line_buf.sv =====
// Line buffer holding the two previous rows of gray values, one entry per column.
// Depends on lef_pkg for the entry type; read data is registered, with write forwarding.
module lef_line_buf #(
  parameter int DEPTH = lef_pkg::MaxWidthDefault
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output lef_pkg::line_entry_t         rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  lef_pkg::line_entry_t         wr_data
);

  lef_pkg::line_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry being written in the same cycle returns the new word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule
